// ===== sv/window_similarity_3x3_assert.svh =====
// Assertion macros shared by the window similarity RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef WINDOW_SIMILARITY_3X3_ASSERT_SVH
`define WINDOW_SIMILARITY_3X3_ASSERT_SVH
`ifndef SYNTHESIS
// Plain condition checked at every rising clock edge out of reset.
`define WSIM_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("wsim assertion failed");
// Same-cycle implication.
`define WSIM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsim assertion failed");
// Next-cycle implication.
`define WSIM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsim assertion failed");
`else
`define WSIM_ASSERT(label, clk, rst_n, cond)
`define WSIM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WSIM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/wsim_pkg.sv =====
// Types and constants of the window similarity block.
// No dependencies; imported by the interfaces and every module.
package wsim_pkg;

    localparam int PIX_W      = 8;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int MIN_DIM    = 3;

    localparam logic [COL_W-1:0] FW_RESET = 11'd640;
    localparam logic [ROW_W-1:0] FH_RESET = 12'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // Arithmetic widths: window sums up to 2295, numerator below 2^26,
    // denominator below 2^16, rounded-up dividend below 2^27.
    localparam int CSUM_W    = 10;
    localparam int WSUM_W    = 12;
    localparam int NUM_W     = 26;
    localparam int DEN_W     = 16;
    localparam int REM_W     = 27;
    localparam int Q_W       = 8;
    localparam int DIV_STEPS = 8;
    localparam int ROW_WORD_W = 4 * PIX_W;

    localparam logic [14:0] NUM_SCALE = 15'd20400;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic {
        OP_PIXEL,
        OP_TAIL
    } t_op_kind;

    typedef struct packed {
        t_op_kind             kind;
        logic [PIX_W-1:0]     pixel_a;
        logic [PIX_W-1:0]     pixel_b;
        logic [COL_W-1:0]     col;
        logic                 interior;
        logic                 emit;
        logic                 frame_end;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic valid;
        logic emit;
        logic frame_end;
        logic keep;
    } t_tag;

endpackage

// ===== sv/wsim_in_if.sv =====
// Input channel of the window similarity block: one pixel pair per transaction.
// Depends on wsim_pkg.
interface wsim_in_if;
    import wsim_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_a;
    logic [PIX_W-1:0] pixel_b;
    logic             drain;

    modport source (output valid, output pixel_a, output pixel_b, output drain, input ready);
    modport sink   (input valid, input pixel_a, input pixel_b, input drain, output ready);
endinterface

// ===== sv/wsim_out_if.sv =====
// Output channel of the window similarity block: one result per transaction.
// Depends on wsim_pkg.
interface wsim_out_if;
    import wsim_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] similarity;
    logic             frame_end;

    modport source (output valid, output similarity, output frame_end, input ready);
    modport sink   (input valid, input similarity, input frame_end, output ready);
endinterface

// ===== sv/wsim_fifo.sv =====
// Short operation queue between the front and back parts.
// Depends on wsim_pkg and window_similarity_3x3_assert.svh.
`include "window_similarity_3x3_assert.svh"
module wsim_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsim_pkg::t_op     i_op,
    input  logic              i_pop,
    output wsim_pkg::t_op     o_head,
    output wsim_pkg::t_q_stat o_q
);
    import wsim_pkg::*;

    t_op               r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rp];
    assign o_q.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_q.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `WSIM_ASSERT_IMP(a_no_push_when_full, i_clk, i_rst_n, o_q.full, !i_push)
    `WSIM_ASSERT_IMP(a_no_pop_when_empty, i_clk, i_rst_n, o_q.empty, !i_pop)
endmodule

// ===== sv/wsim_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, eight stages.
// Depends on wsim_pkg.
module wsim_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [wsim_pkg::REM_W-1:0] i_rem,
    input  logic [wsim_pkg::DEN_W-1:0] i_den,
    input  wsim_pkg::t_tag             i_tag,
    output logic [wsim_pkg::Q_W-1:0]   o_q,
    output wsim_pkg::t_tag             o_tag
);
    import wsim_pkg::*;

    logic [REM_W-1:0] r_rem [DIV_STEPS];
    logic [DEN_W-1:0] r_den [DIV_STEPS];
    logic [Q_W-1:0]   r_q   [DIV_STEPS];
    t_tag             r_tag [DIV_STEPS];

    logic [REM_W-1:0] c_rem [DIV_STEPS];
    logic [DEN_W-1:0] c_den [DIV_STEPS];
    logic [Q_W-1:0]   c_q   [DIV_STEPS];
    t_tag             c_tag [DIV_STEPS];
    logic [REM_W-1:0] c_sh  [DIV_STEPS];
    logic [REM_W-1:0] n_rem [DIV_STEPS];
    logic [Q_W-1:0]   n_q   [DIV_STEPS];

    always_comb begin
        c_rem[0] = i_rem;
        c_den[0] = i_den;
        c_q[0]   = '0;
        c_tag[0] = i_tag;
        for (int s = 1; s < DIV_STEPS; s++) begin
            c_rem[s] = r_rem[s-1];
            c_den[s] = r_den[s-1];
            c_q[s]   = r_q[s-1];
            c_tag[s] = r_tag[s-1];
        end
        // Stage s decides quotient bit DIV_STEPS-1-s.
        for (int s = 0; s < DIV_STEPS; s++) begin
            c_sh[s] = REM_W'(c_den[s]) << (DIV_STEPS - 1 - s);
            if (c_rem[s] >= c_sh[s]) begin
                n_rem[s] = c_rem[s] - c_sh[s];
                n_q[s]   = c_q[s] | (Q_W'(1) << (DIV_STEPS - 1 - s));
            end else begin
                n_rem[s] = c_rem[s];
                n_q[s]   = c_q[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= c_den[s];
                r_q[s]   <= n_q[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_tag[s] <= '0;
            end
        end else if (i_en) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_tag[s] <= c_tag[s];
            end
        end
    end

    assign o_q   = r_q[DIV_STEPS-1];
    assign o_tag = r_tag[DIV_STEPS-1];
endmodule

// ===== sv/wsim_front.sv =====
// Front part: configuration registers, raster counters and item classification.
// Depends on wsim_pkg and wsim_in_if.
module wsim_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wsim_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wsim_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wsim_in_if.sink                         i_pix,
    input  wsim_pkg::t_q_stat               i_q,
    output logic                            o_push,
    output wsim_pkg::t_op                   o_op
);
    import wsim_pkg::*;

    localparam int EXT_W = COL_W + 2;
    localparam logic [EXT_W-1:0] MAX_W_EXT = EXT_W'(MAX_WIDTH);

    logic [COL_W-1:0] r_fw;
    logic [ROW_W-1:0] r_fh;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic [EXT_W-1:0] fw_ext;
    logic [COL_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;
    logic [COL_W-1:0] col_inc;
    logic             acc;
    logic             in_frame;

    // Clamp the width to 3..MAX_WIDTH, what the row store holds, and the height to at least 3.
    always_comb begin
        fw_ext = EXT_W'(r_fw);
        if (fw_ext < EXT_W'(MIN_DIM)) begin
            eff_w = COL_W'(MIN_DIM);
        end else if (fw_ext > MAX_W_EXT) begin
            eff_w = COL_W'(MAX_W_EXT);
        end else begin
            eff_w = r_fw;
        end
        eff_h = (r_fh < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : r_fh;
    end

    assign i_pix.ready = !i_q.full;
    assign acc         = i_pix.valid && i_pix.ready;
    assign in_frame    = (r_row < eff_h) && (r_col < eff_w);
    assign col_inc     = r_col + COL_W'(1);

    always_comb begin
        n_col           = r_col;
        n_row           = r_row;
        o_push          = 1'b0;
        o_op.kind       = OP_PIXEL;
        o_op.pixel_a    = i_pix.pixel_a;
        o_op.pixel_b    = i_pix.pixel_b;
        o_op.col        = r_col;
        o_op.interior   = 1'b0;
        o_op.emit       = 1'b0;
        o_op.frame_end  = 1'b0;
        if (acc) begin
            if (in_frame) begin
                // Drop drain items while frame pixels are still expected.
                if (!i_pix.drain) begin
                    o_push        = 1'b1;
                    o_op.interior = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
                    o_op.emit     = (r_row >= ROW_W'(2)) ||
                                    ((r_row == ROW_W'(1)) && (r_col != '0));
                    if (col_inc >= eff_w) begin
                        n_col = '0;
                        n_row = r_row + ROW_W'(1);
                    end else begin
                        n_col = col_inc;
                    end
                end
            end else begin
                // Tail: every item flushes one border result.
                o_push         = 1'b1;
                o_op.kind      = OP_TAIL;
                o_op.emit      = 1'b1;
                o_op.frame_end = (r_col >= eff_w);
                if (r_col >= eff_w) begin
                    n_col = '0;
                    n_row = '0;
                end else begin
                    n_col = col_inc;
                    if (r_row < eff_h) begin
                        n_row = eff_h;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= FW_RESET;
            r_fh  <= FH_RESET;
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH: begin
                    r_fw  <= i_cfg_data[COL_W-1:0];
                    r_col <= '0;
                    r_row <= '0;
                end
                CFG_FRAME_HEIGHT: begin
                    r_fh  <= i_cfg_data[ROW_W-1:0];
                    r_col <= '0;
                    r_row <= '0;
                end
                default: begin
                    r_col <= n_col;
                    r_row <= n_row;
                end
            endcase
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end
endmodule

// ===== sv/wsim_back.sv =====
// Back part: row-store memory, column sums, ratio arithmetic and output register.
// Depends on wsim_pkg, wsim_out_if, wsim_div and window_similarity_3x3_assert.svh.
`include "window_similarity_3x3_assert.svh"
module wsim_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wsim_pkg::t_op     i_head,
    input  wsim_pkg::t_q_stat i_q,
    output logic              o_pop,
    wsim_out_if.source        o_sim
);
    import wsim_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Row store: {a two rows up, a one row up, b two rows up, b one row up}.
    logic [ROW_WORD_W-1:0] r_rows [MAX_WIDTH];

    logic                  adv;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;

    // Stage 1: operation and row-store read data
    logic                  r1_v;
    t_op                   r1_op;
    logic [ROW_WORD_W-1:0] r1_rd;
    logic [CSUM_W-1:0]     col_a;
    logic [CSUM_W-1:0]     col_b;
    logic [CSUM_W-1:0]     r_cs_a1;
    logic [CSUM_W-1:0]     r_cs_a2;
    logic [CSUM_W-1:0]     r_cs_b1;
    logic [CSUM_W-1:0]     r_cs_b2;
    logic                  r1_pix;

    // Stage 2: window sums
    t_tag                  r2_tag;
    logic [WSUM_W-1:0]     r2_sa;
    logic [WSUM_W-1:0]     r2_sb;
    logic [WSUM_W-1:0]     diff;
    logic [WSUM_W:0]       sum;

    // Stage 3: numerator and denominator
    t_tag                  r3_tag;
    logic [NUM_W-1:0]      r3_num;
    logic [DEN_W-1:0]      r3_den;
    logic [DEN_W+7:0]      den255;
    logic                  over;

    // Stage 4: rounded-up dividend into the divider
    t_tag                  r4_tag;
    logic [REM_W-1:0]      r4_rem;
    logic [DEN_W-1:0]      r4_den;

    logic [Q_W-1:0]        div_q;
    t_tag                  div_tag;

    logic                  r_out_valid;
    logic [PIX_W-1:0]      r_out_sim;
    logic                  r_out_end;

    // The whole back pipeline moves when the output register can take a result.
    assign adv     = !r_out_valid || o_sim.ready;
    assign o_pop   = adv && !i_q.empty;
    assign rd_addr = AW'(i_head.col);
    assign wr_addr = AW'(r1_op.col);
    assign r1_pix  = r1_v && (r1_op.kind == OP_PIXEL);

    assign col_a = CSUM_W'(r1_rd[4*PIX_W-1:3*PIX_W]) + CSUM_W'(r1_rd[3*PIX_W-1:2*PIX_W])
                 + CSUM_W'(r1_op.pixel_a);
    assign col_b = CSUM_W'(r1_rd[2*PIX_W-1:PIX_W]) + CSUM_W'(r1_rd[PIX_W-1:0])
                 + CSUM_W'(r1_op.pixel_b);

    assign diff   = (r2_sa >= r2_sb) ? (r2_sa - r2_sb) : (r2_sb - r2_sa);
    assign sum    = {1'b0, r2_sa} + {1'b0, r2_sb};
    assign den255 = {r3_den, 8'd0} - {8'd0, r3_den};
    assign over   = r3_num > NUM_W'(den255);

    // Row store: read the next column while writing back the current one.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_rd <= r_rows[rd_addr];
            if (r1_pix) begin
                r_rows[wr_addr] <= {r1_rd[3*PIX_W-1:2*PIX_W], r1_op.pixel_a,
                                    r1_rd[PIX_W-1:0], r1_op.pixel_b};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_op <= i_head;
            if (r1_pix) begin
                r_cs_a1 <= r_cs_a2;
                r_cs_a2 <= col_a;
                r_cs_b1 <= r_cs_b2;
                r_cs_b2 <= col_b;
            end
            r2_sa  <= WSUM_W'(r_cs_a1) + WSUM_W'(r_cs_a2) + WSUM_W'(col_a);
            r2_sb  <= WSUM_W'(r_cs_b1) + WSUM_W'(r_cs_b2) + WSUM_W'(col_b);
            r3_num <= NUM_W'(diff) * NUM_W'(NUM_SCALE);
            r3_den <= DEN_W'({sum, 3'd0}) + DEN_W'({sum, 1'd0}) + DEN_W'(1);
            // Ceiling division: divide num + den - 1.
            r4_rem <= REM_W'(r3_num) + REM_W'(r3_den) - REM_W'(1);
            r4_den <= r3_den;
            r_out_sim <= div_tag.keep ? ~div_q : '0;
            r_out_end <= div_tag.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_tag      <= '0;
            r3_tag      <= '0;
            r4_tag      <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r1_v             <= !i_q.empty;
            r2_tag.valid     <= r1_v;
            r2_tag.emit      <= r1_op.emit;
            r2_tag.frame_end <= r1_op.frame_end;
            r2_tag.keep      <= r1_op.interior;
            r3_tag           <= r2_tag;
            r4_tag.valid     <= r3_tag.valid;
            r4_tag.emit      <= r3_tag.emit;
            r4_tag.frame_end <= r3_tag.frame_end;
            r4_tag.keep      <= r3_tag.keep && !over;
            r_out_valid      <= div_tag.valid && div_tag.emit;
        end
    end

    wsim_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_rem   (r4_rem),
        .i_den   (r4_den),
        .i_tag   (r4_tag),
        .o_q     (div_q),
        .o_tag   (div_tag)
    );

    assign o_sim.valid      = r_out_valid;
    assign o_sim.similarity = r_out_sim;
    assign o_sim.frame_end  = r_out_end;

    `WSIM_ASSERT_IMP(a_frame_end_is_border, i_clk, i_rst_n, r_out_valid && r_out_end, r_out_sim == '0)
    `WSIM_ASSERT_IMP(a_tail_not_interior, i_clk, i_rst_n, r1_v && (r1_op.kind == OP_TAIL), !r1_op.interior && r1_op.emit)
    `WSIM_ASSERT_IMP(a_interior_emits, i_clk, i_rst_n, r1_v && r1_op.interior, r1_op.emit)
    `WSIM_ASSERT_NXT(a_stall_freezes, i_clk, i_rst_n, r_out_valid && !o_sim.ready, $stable(r4_tag) && $stable(r1_v))
endmodule

// ===== sv/window_similarity_3x3.sv =====
// Top level of the 3x3 window similarity block.
// Depends on wsim_pkg, wsim_in_if, wsim_out_if, wsim_front, wsim_fifo and wsim_back.
//
// Two 8-bit images enter together, one co-located pixel pair per input
// transaction, in raster order. For each interior position the block sums the
// 3x3 windows of both images (A and B) and returns 255 - ceil(w), with
// w = |A-B|*20400 / (10*(A+B)+1), or 0 when w exceeds 255; border positions
// return 0. The result for a raster position comes out when the pixel
// width+1 positions later is accepted, so each frame ends with width+1 items
// (drain items or ignored pixels) that flush border zeros, the last one
// flagged frame_end. A drain item sent while frame pixels are still expected
// is taken and dropped. The block sustains one input transaction per clock
// while its operation queue has room; that figure is set by the row store, a
// single MAX_WIDTH x 32-bit memory with one read and one write each cycle, and
// by the divider, eight pipelined stages that resolve one quotient bit each.
// Without stalls, an accepted transaction passes through the four-entry
// operation queue, the four arithmetic stages and the eight divider stages
// into the output register, which then holds the result until it is taken.
// When the output is stalled the back part holds still while the front keeps
// accepting until the queue fills. Writing frame_width (index 0)
// or frame_height (index 1) restarts the frame; write only while the block is
// idle. Sizes are clamped to 3..MAX_WIDTH columns and at least 3 rows. The row
// store and column sums are not cleared after reset or between frames: any
// stale content only feeds border windows, whose result is 0, so there is no
// clearing pass.
module window_similarity_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wsim_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wsim_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wsim_in_if.sink                         i_pix,
    wsim_out_if.source                      o_sim
);
    import wsim_pkg::*;

    // Classified operations travel from front to back through the queue.
    logic    push;
    logic    pop;
    t_op     push_op;
    t_op     head_op;
    t_q_stat q_stat;

    wsim_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q        (q_stat),
        .o_push     (push),
        .o_op       (push_op)
    );

    // Hold up to four operations so either side can stall on its own.
    wsim_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_q     (q_stat)
    );

    // Advance the window arithmetic whenever the output register frees up.
    wsim_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_op),
        .i_q     (q_stat),
        .o_pop   (pop),
        .o_sim   (o_sim)
    );
endmodule

// ===== test/tb_window_similarity_3x3.sv =====
// Self-checking testbench for window_similarity_3x3: streams pixel pairs under several
// frame sizes and handshake pressures and checks every result against a local predictor.
// Depends on wsim_pkg, wsim_in_if, wsim_out_if and the window_similarity_3x3 RTL.
module tb_window_similarity_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    import wsim_pkg::*;

    localparam int          HALF_PERIOD  = 5;
    localparam int          MAX_COLS     = 1024;
    localparam int          DRAIN_CYCLES = 40;       // outlasts the back pipeline
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          RANDOM_ITEMS = 300;
    localparam int unsigned SCORE_SCALE  = 20400;    // 2040 / 0.1, kept integral
    localparam int unsigned SCORE_TOP    = 255;

    // Index that decodes to no register: a write there must not restart the frame.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;

    typedef enum int {
        TEX_UNIFORM,     // independent noise in both images
        TEX_CORRELATED,  // second image close to the first: scores near the top
        TEX_DARK,        // tiny sums: ratio blows past the cutoff
        TEX_BINARY       // only 0 and 255
    } t_texture;

    typedef enum int {
        PRESS_NONE,
        PRESS_SENDER,
        PRESS_RECEIVER,
        PRESS_BOTH
    } t_pressure;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_a;
        logic [PIX_W-1:0] pixel_b;
        logic             drain;
    } t_pix_item;

    typedef struct packed {
        logic [PIX_W-1:0] similarity;
        logic             frame_end;
    } t_score;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    wsim_in_if  pix_if ();
    wsim_out_if sim_if ();

    window_similarity_3x3 #(
        .MAX_WIDTH (MAX_COLS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_sim      (sim_if)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Stimulus and expectations
    t_pix_item   pixel_queue [$];
    t_score      pending_scores [$];
    int unsigned queued_count;
    int unsigned error_count;
    int unsigned results_seen;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Predictor state: row history per image (high byte two rows up, low byte
    // one row up), vertical 3-pixel sums of the last three columns, raster position.
    logic [15:0] line_buf [2][MAX_COLS];
    int unsigned col_sum  [2][3];
    int unsigned col_idx;
    int unsigned row_idx;
    int unsigned reg_width;
    int unsigned reg_height;

    logic      in_fire;
    logic      out_fire;
    logic      in_taken;
    t_pix_item next_item;
    t_pix_item seen_item;
    t_score    want;

    assign in_fire  = pix_if.valid && (pix_if.ready === 1'b1);
    assign out_fire = (sim_if.valid === 1'b1) && sim_if.ready;

    function automatic int unsigned eff_width();
        if (reg_width < MIN_DIM) return MIN_DIM;
        if (reg_width > MAX_COLS) return MAX_COLS;
        return reg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (reg_height < MIN_DIM) return MIN_DIM;
        return reg_height;
    endfunction

    // 255 - ceil(|A-B|*20400 / (10(A+B)+1)), or 0 once the ratio passes 255.
    function automatic logic [PIX_W-1:0] window_score(int unsigned sa, int unsigned sb);
        longint unsigned diff;
        longint unsigned num;
        longint unsigned den;
        diff = (sa > sb) ? longint'(sa - sb) : longint'(sb - sa);
        num  = diff * SCORE_SCALE;
        den  = 10 * (longint'(sa) + longint'(sb)) + 1;
        if (num > SCORE_TOP * den) return '0;
        return PIX_W'(SCORE_TOP - (num + den - 1) / den);
    endfunction

    task automatic reset_predictor();
        for (int k = 0; k < 2; k++) begin
            for (int c = 0; c < MAX_COLS; c++) line_buf[k][c] = '0;
            for (int j = 0; j < 3; j++) col_sum[k][j] = 0;
        end
        reg_width  = FW_RESET;
        reg_height = FH_RESET;
        col_idx    = 0;
        row_idx    = 0;
    endtask

    // Any decoded register write restarts the frame; unknown indexes do nothing.
    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_FRAME_WIDTH) begin
            reg_width = data[COL_W-1:0];
        end else if (idx == CFG_FRAME_HEIGHT) begin
            reg_height = data[ROW_W-1:0];
        end else begin
            return;
        end
        col_idx = 0;
        row_idx = 0;
    endtask

    // Advance the raster by one accepted transaction and queue the result it releases.
    task automatic advance_window(input t_pix_item it);
        int unsigned      w;
        int unsigned      h;
        int unsigned      r;
        int unsigned      c;
        int unsigned      sa;
        int unsigned      sb;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] pix;
        t_score           res;
        w   = eff_width();
        h   = eff_height();
        res = '0;
        if (row_idx < h && col_idx < w) begin
            // Drop a drain while frame pixels are still due.
            if (it.drain) return;
            r = row_idx;
            c = col_idx;
            for (int k = 0; k < 2; k++) begin
                pix = (k == 0) ? it.pixel_a : it.pixel_b;
                top = line_buf[k][c][15:8];
                mid = line_buf[k][c][7:0];
                line_buf[k][c] = {mid, pix};
                col_sum[k][0] = col_sum[k][1];
                col_sum[k][1] = col_sum[k][2];
                col_sum[k][2] = int'(top) + int'(mid) + int'(pix);
            end
            // Window centered one row up and one column left is interior here.
            if (r >= 2 && c >= 2) begin
                sa = col_sum[0][0] + col_sum[0][1] + col_sum[0][2];
                sb = col_sum[1][0] + col_sum[1][1] + col_sum[1][2];
                res.similarity = window_score(sa, sb);
            end
            col_idx = c + 1;
            if (col_idx >= w) begin
                col_idx = 0;
                row_idx = r + 1;
            end
            // Nothing comes out until the raster is width+1 positions in.
            if (r > 1 || (r == 1 && c >= 1)) pending_scores.push_back(res);
        end else begin
            // Tail: every transaction flushes one border zero, the last one flagged.
            res.frame_end = (col_idx >= w);
            if (col_idx >= w) begin
                col_idx = 0;
                row_idx = 0;
            end else begin
                col_idx = col_idx + 1;
                if (row_idx < h) row_idx = h;
            end
            pending_scores.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, what);
    endtask

    // Input side: advance to the next item once the current transaction is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || in_taken) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item       = pixel_queue.pop_front();
                pix_if.valid   <= 1'b1;
                pix_if.pixel_a <= next_item.pixel_a;
                pix_if.pixel_b <= next_item.pixel_b;
                pix_if.drain   <= next_item.drain;
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
        sim_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check results before predicting: results leave through a deep registered pipeline.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (out_fire) begin
                if (pending_scores.size() == 0) begin
                    report_mismatch($sformatf("unexpected result similarity=%0d frame_end=%0b",
                                              sim_if.similarity, sim_if.frame_end));
                end else begin
                    want = pending_scores.pop_front();
                    if (sim_if.similarity !== want.similarity)
                        report_mismatch($sformatf("similarity got %0d want %0d",
                                                  sim_if.similarity, want.similarity));
                    if (sim_if.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end got %0b want %0b",
                                                  sim_if.frame_end, want.frame_end));
                end
                results_seen++;
            end
            if (in_fire) begin
                seen_item.pixel_a = pix_if.pixel_a;
                seen_item.pixel_b = pix_if.pixel_b;
                seen_item.drain   = pix_if.drain;
                advance_window(seen_item);
            end
            in_taken <= in_fire;
        end
    end

    // Hard stop in case the block hangs or loses results.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic set_pressure(input t_pressure mode);
        send_idle_pct  = (mode == PRESS_SENDER || mode == PRESS_RECEIVER) ?
                         ((mode == PRESS_SENDER) ? 78 : 0) : ((mode == PRESS_BOTH) ? 23 : 0);
        recv_stall_pct = (mode == PRESS_RECEIVER) ? 78 : ((mode == PRESS_BOTH) ? 23 : 0);
    endtask

    // Write one register; the predictor follows at the same point since the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold until every item is taken and every result is back, then let the pipe empty.
    task automatic settle();
        while (pixel_queue.size() != 0 || pix_if.valid || pending_scores.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_item(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                             input logic drain);
        t_pix_item it;
        it.pixel_a = a;
        it.pixel_b = b;
        it.drain   = drain;
        pixel_queue.push_back(it);
    endtask

    function automatic t_pix_item make_pixel(input t_texture tex);
        t_pix_item it;
        int        v;
        it.drain   = 1'b0;
        it.pixel_a = PIX_W'($urandom_range(255));
        it.pixel_b = PIX_W'($urandom_range(255));
        case (tex)
            TEX_CORRELATED: begin
                v = int'(it.pixel_a) + int'($urandom_range(8)) - 4;
                it.pixel_b = (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : PIX_W'(v));
            end
            TEX_DARK: begin
                it.pixel_a = PIX_W'($urandom_range(7));
                it.pixel_b = PIX_W'($urandom_range(7));
            end
            TEX_BINARY: begin
                it.pixel_a = $urandom_range(1) ? 8'hFF : 8'h00;
                it.pixel_b = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
        return it;
    endfunction

    // Queue npix pixels of a frame of width w, with stray drains mixed in, and
    // optionally the width+1 flush items; some flush items carry ignored pixels.
    task automatic queue_frame(input int unsigned w, input int unsigned npix,
                               input t_texture tex, input bit with_tail);
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(19) == 0)
                push_item(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)), 1'b1);
            pixel_queue.push_back(make_pixel(tex));
            queued_count++;
        end
        if (with_tail) begin
            for (int t = 0; t <= w; t++) begin
                push_item(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
                          $urandom_range(2) != 0);
                queued_count++;
            end
        end
    endtask

    initial begin
        int unsigned      phase;
        int unsigned      raw_w;
        int unsigned      raw_h;
        int unsigned      which;
        int unsigned      frames;
        int unsigned      w;
        int unsigned      h;
        t_texture         tex;
        // Quiet, known inputs from time zero.
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_FRAME_WIDTH;
        i_cfg_data     = '0;
        pix_if.valid   = 1'b0;
        pix_if.pixel_a = '0;
        pix_if.pixel_b = '0;
        pix_if.drain   = 1'b0;
        sim_if.ready   = 1'b0;
        error_count    = 0;
        results_seen   = 0;
        cycle_count    = 0;
        queued_count   = 0;
        set_pressure(PRESS_NONE);
        reset_predictor();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry (640 wide): run just past one row so a few border zeros come out.
        queue_frame(FW_RESET, FW_RESET + 4, TEX_UNIFORM, 1'b0);
        settle();

        // Smallest frame: one interior window. First a maximal difference (score 0),
        // with a drain inside the frame and a pixel during the flush, both ignored.
        write_reg(CFG_FRAME_WIDTH, 12'd3);
        write_reg(CFG_FRAME_HEIGHT, 12'd3);
        push_item(8'd17, 8'd99, 1'b1);
        repeat (9) push_item(8'hFF, 8'h00, 1'b0);
        push_item(8'hA5, 8'h5A, 1'b0);
        repeat (3) push_item(8'h00, 8'h00, 1'b1);
        // Identical images of alternating black and white pixels: full score.
        for (int i = 0; i < 9; i++) push_item(i[0] ? 8'hFF : 8'h00, i[0] ? 8'hFF : 8'h00, 1'b0);
        repeat (4) push_item(8'hFF, 8'hFF, 1'b1);
        settle();

        // Sizes below the minimum clamp to 3x3.
        set_pressure(PRESS_SENDER);
        write_reg(CFG_FRAME_WIDTH, 12'd0);
        write_reg(CFG_FRAME_HEIGHT, 12'd0);
        queue_frame(3, 9, TEX_BINARY, 1'b1);
        queue_frame(3, 9, TEX_DARK, 1'b1);
        settle();

        // Widest frame: 2047 clamps to the row store size; height 1 clamps to 3.
        // Run just past the first row: the wrap at the clamped width sets when
        // results start, and an unclamped height would flush one result early.
        set_pressure(PRESS_BOTH);
        write_reg(CFG_FRAME_WIDTH, 12'd2047);
        write_reg(CFG_FRAME_HEIGHT, 12'd1);
        queue_frame(MAX_COLS, MAX_COLS + 4, TEX_CORRELATED, 1'b0);
        settle();

        // Tallest frame, left unfinished. A write to an unused index must leave the
        // frame position alone, so the pixels after it carry on the same frame.
        set_pressure(PRESS_RECEIVER);
        write_reg(CFG_FRAME_WIDTH, 12'd1);
        write_reg(CFG_FRAME_HEIGHT, 12'd4095);
        queue_frame(3, 60, TEX_UNIFORM, 1'b0);
        settle();
        write_reg(CFG_UNUSED, 12'($urandom_range(4095)));
        queue_frame(3, 30, TEX_CORRELATED, 1'b0);
        settle();

        // Random part: small frames mostly whole, sometimes cut short by a restart.
        queued_count = 0;
        phase        = 0;
        while (queued_count < RANDOM_ITEMS) begin
            set_pressure(t_pressure'(phase % 4));
            raw_w = ($urandom_range(9) == 0) ? $urandom_range(2) :
                    (($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12));
            raw_h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
            which = (phase == 0) ? 2 : $urandom_range(2);
            if (which != 1)
                write_reg(CFG_FRAME_WIDTH, {1'($urandom_range(1)), COL_W'(raw_w)});
            if (which != 0)
                write_reg(CFG_FRAME_HEIGHT, ROW_W'(raw_h));
            w      = eff_width();
            h      = eff_height();
            frames = $urandom_range(1, 2);
            for (int f = 0; f < frames; f++) begin
                tex = t_texture'($urandom_range(3));
                if (f == frames - 1 && $urandom_range(3) == 0)
                    queue_frame(w, $urandom_range(1, w * h - 1), tex, 1'b0);
                else
                    queue_frame(w, w * h, tex, 1'b1);
            end
            settle();
            phase++;
        end

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
